// ===== hdl/sorted_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Shared macros for the concurrent checks of the queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, operation and status codes, and the controller interface.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_W   = 16;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = KEY_W + TAG_W;

  localparam logic [1:0] OP_OFFER = 2'd0;
  localparam logic [1:0] OP_POLL  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic rd_idx;
    logic rd_idx_m1;
    logic rd_head;
    logic idx_inc;
    logic idx_dec;
    logic idx_one;
    logic idx_from_cnt;
    logic set_pos;
    logic wr_shift_up;
    logic wr_shift_down;
    logic wr_new;
    logic cnt_inc;
    logic cnt_dec;
    logic set_ins;
    logic set_full;
    logic set_empty;
    logic cap_removed;
    logic cap_head;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       idx_eq_cnt;
    logic       idx_gt_pos;
    logic       key_first;
  } sts_t;

endpackage

// ===== hdl/spq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/spq_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Entry RAM, count, index and position registers, key compare and results.
// ----------------------------------------------------------------------------
module spq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spq_pkg::cmd_t             cmd,
  output spq_pkg::sts_t             sts,
  input  logic                      cfg_we,
  input  logic                      cfg_descending_order,
  input  logic [1:0]                in_opcode,
  input  logic [spq_pkg::KEY_W-1:0] in_item_key,
  input  logic [spq_pkg::TAG_W-1:0] in_item_tag,
  output logic [1:0]                out_status,
  output logic [3:0]                out_insert_index,
  output logic [spq_pkg::KEY_W-1:0] out_removed_key,
  output logic [spq_pkg::TAG_W-1:0] out_removed_tag,
  output logic                      out_head_valid,
  output logic [spq_pkg::KEY_W-1:0] out_head_key,
  output logic [spq_pkg::TAG_W-1:0] out_head_tag,
  output logic [4:0]                out_count
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic                      desc_r;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             idx_r;
  logic [CW-1:0]             pos_r;
  logic [1:0]                op_r;
  logic [spq_pkg::KEY_W-1:0] key_r;
  logic [spq_pkg::TAG_W-1:0] tag_r;
  logic [1:0]                status_r;
  logic [AW-1:0]             ins_r;
  logic [spq_pkg::KEY_W-1:0] rkey_r;
  logic [spq_pkg::TAG_W-1:0] rtag_r;
  logic                      hvalid_r;
  logic [spq_pkg::KEY_W-1:0] hkey_r;
  logic [spq_pkg::TAG_W-1:0] htag_r;

  logic [CW-1:0]               idx_m1;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               waddr;
  logic [spq_pkg::ENTRY_W-1:0] wdata;
  logic [spq_pkg::ENTRY_W-1:0] rdata;
  logic                        we;
  logic [spq_pkg::KEY_W-1:0]   rd_key;
  logic [spq_pkg::TAG_W-1:0]   rd_tag;
  logic [AW+3:0]               ins_ext;
  logic [CW+4:0]               cnt_ext;

  assign idx_m1 = idx_r - 1'b1;
  assign rd_key = rdata[spq_pkg::ENTRY_W-1:spq_pkg::TAG_W];
  assign rd_tag = rdata[spq_pkg::TAG_W-1:0];

  always_comb begin
    if (cmd.rd_head) begin
      raddr = '0;
    end else if (cmd.rd_idx_m1) begin
      raddr = idx_m1[AW-1:0];
    end else if (cmd.rd_idx) begin
      raddr = idx_r[AW-1:0];
    end else begin
      raddr = '0;
    end
  end

  always_comb begin
    we    = cmd.wr_new | cmd.wr_shift_up | cmd.wr_shift_down;
    wdata = rdata;
    waddr = idx_r[AW-1:0];
    if (cmd.wr_new) begin
      waddr = pos_r[AW-1:0];
      wdata = {key_r, tag_r};
    end else if (cmd.wr_shift_down) begin
      waddr = idx_m1[AW-1:0];
    end
  end

  spq_ram #(
    .WIDTH (spq_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.op         = op_r;
    sts.full       = (cnt_r == DEPTH_C);
    sts.empty      = (cnt_r == '0);
    sts.idx_eq_cnt = (idx_r == cnt_r);
    sts.idx_gt_pos = (idx_r > pos_r);
    sts.key_first  = desc_r ? (key_r > rd_key) : (key_r < rd_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
      cnt_r  <= '0;
      idx_r  <= '0;
      pos_r  <= '0;
    end else begin
      if (cfg_we) begin
        desc_r <= cfg_descending_order;
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.idx_from_cnt) begin
        idx_r <= cnt_r;
      end else if (cmd.idx_one) begin
        idx_r <= CW'(1);
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end else if (cmd.idx_dec) begin
        idx_r <= idx_m1;
      end
      if (cmd.set_pos) begin
        pos_r <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      key_r    <= in_item_key;
      tag_r    <= in_item_tag;
      status_r <= spq_pkg::STS_OK;
      ins_r    <= '0;
      rkey_r   <= '0;
      rtag_r   <= '0;
    end else begin
      if (cmd.set_full) begin
        status_r <= spq_pkg::STS_FULL;
      end
      if (cmd.set_empty) begin
        status_r <= spq_pkg::STS_EMPTY;
      end
      if (cmd.set_ins) begin
        ins_r <= pos_r[AW-1:0];
      end
      if (cmd.cap_removed) begin
        rkey_r <= rd_key;
        rtag_r <= rd_tag;
      end
    end
    if (cmd.cap_head) begin
      hvalid_r <= (cnt_r != '0);
      hkey_r   <= (cnt_r != '0) ? rd_key : '0;
      htag_r   <= (cnt_r != '0) ? rd_tag : '0;
    end
  end

  assign ins_ext = {{4{1'b0}}, ins_r};
  assign cnt_ext = {{5{1'b0}}, cnt_r};

  assign out_status       = status_r;
  assign out_insert_index = ins_ext[3:0];
  assign out_removed_key  = rkey_r;
  assign out_removed_tag  = rtag_r;
  assign out_head_valid   = hvalid_r;
  assign out_head_key     = hkey_r;
  assign out_head_tag     = htag_r;
  assign out_count        = cnt_ext[4:0];

endmodule

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences search and shift where needed, then head read and result strobe.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  spq_pkg::sts_t sts,
  output spq_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_PL_CAP,
    S_PD_RD,
    S_PD_WR,
    S_HD_RD,
    S_HD_CAP,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          spq_pkg::OP_OFFER: begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = S_HD_RD;
            end else begin
              state_nxt = S_SRCH_RD;
            end
          end
          spq_pkg::OP_POLL: begin
            if (sts.empty) begin
              cmd.set_empty = 1'b1;
              state_nxt     = S_HD_RD;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_PL_CAP;
            end
          end
          default: begin
            state_nxt = S_HD_RD;
          end
        endcase
      end
      S_SRCH_RD: begin
        if (sts.idx_eq_cnt) begin
          cmd.set_pos      = 1'b1;
          cmd.idx_from_cnt = 1'b1;
          state_nxt        = S_SH_RD;
        end else begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.key_first) begin
          cmd.set_pos      = 1'b1;
          cmd.idx_from_cnt = 1'b1;
          state_nxt        = S_SH_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        if (sts.idx_gt_pos) begin
          cmd.rd_idx_m1 = 1'b1;
          state_nxt     = S_SH_WR;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift_up = 1'b1;
        cmd.idx_dec     = 1'b1;
        state_nxt       = S_SH_RD;
      end
      S_INS_WR: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.set_ins = 1'b1;
        state_nxt   = S_HD_RD;
      end
      S_PL_CAP: begin
        cmd.cap_removed = 1'b1;
        cmd.idx_one     = 1'b1;
        state_nxt       = S_PD_RD;
      end
      S_PD_RD: begin
        if (sts.idx_eq_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_HD_RD;
        end else begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_PD_WR;
        end
      end
      S_PD_WR: begin
        cmd.wr_shift_down = 1'b1;
        cmd.idx_inc       = 1'b1;
        state_nxt         = S_PD_RD;
      end
      S_HD_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_HD_CAP;
      end
      S_HD_CAP: begin
        cmd.cap_head = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_DONE);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Stable sorted queue of key and tag entries with offer, poll and query.
//
//   Channel  Handshake            Transfer when
//   in_      start / busy         start high and busy low
//   out_     out_valid strobe     every cycle with out_valid high
//   cfg_     cfg_valid/cfg_ready  cfg_valid and cfg_ready high
//
// An offer walks the entry RAM through its single read port once for the
// search and once for the shift, a poll once for its shift; a query, a
// dropped offer or a poll on an empty queue only reads the head.
// Synchronous active-low reset empties the queue and selects ascending order.
// The strobe lasts one cycle and cannot be stalled; busy falls as it ends.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic [spq_pkg::KEY_W-1:0] in_item_key,
  input  logic [spq_pkg::TAG_W-1:0] in_item_tag,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_descending_order,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [3:0]                out_insert_index,
  output logic [spq_pkg::KEY_W-1:0] out_removed_key,
  output logic [spq_pkg::TAG_W-1:0] out_removed_tag,
  output logic                      out_head_valid,
  output logic [spq_pkg::KEY_W-1:0] out_head_key,
  output logic [spq_pkg::TAG_W-1:0] out_head_tag,
  output logic [4:0]                out_count
);

  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_valid & cfg_ready),
    .cfg_descending_order (cfg_descending_order),
    .in_opcode            (in_opcode),
    .in_item_key          (in_item_key),
    .in_item_tag          (in_item_tag),
    .out_status           (out_status),
    .out_insert_index     (out_insert_index),
    .out_removed_key      (out_removed_key),
    .out_removed_tag      (out_removed_tag),
    .out_head_valid       (out_head_valid),
    .out_head_key         (out_head_key),
    .out_head_tag         (out_head_tag),
    .out_count            (out_count)
  );

endmodule

// ===== hdl/spq_chk.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks of command sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module spq_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_head_valid,
  input logic [4:0] out_count
);

  `SPQ_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "Command did not raise busy")
  `SPQ_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_valid, busy, "Result strobe outside a command")
  `SPQ_ASSERT_NXT(a_strobe_once, clk, rst_n, out_valid, !out_valid && !busy, "Strobe not single")
  `SPQ_ASSERT_IMP(a_head_count, clk, rst_n, out_valid, out_head_valid == (out_count != 5'd0), "Head/count mismatch")

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Sends offer, poll and query commands with random gaps and checks every
// result strobe against a behavioural queue kept in the bench. Directed tests
// cover the empty queue, both sort orders, equal keys and the full queue;
// random phases then alternate the sort order with bursts that fill and drain.
// ----------------------------------------------------------------------------
module tb;

  localparam int          QUEUE_DEPTH    = 16;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          MAX_REPORTS    = 10;
  localparam int          RANDOM_PHASES  = 4;
  localparam int          PHASE_ITEMS    = 385;
  localparam logic [1:0]  OP_RESERVED    = 2'd3;

  typedef struct packed {
    logic [1:0]                status;
    logic [3:0]                insert_index;
    logic [spq_pkg::KEY_W-1:0] removed_key;
    logic [spq_pkg::TAG_W-1:0] removed_tag;
    logic                      head_valid;
    logic [spq_pkg::KEY_W-1:0] head_key;
    logic [spq_pkg::TAG_W-1:0] head_tag;
    logic [4:0]                count;
  } queue_result_t;

  typedef enum int {FILL_BURST, DRAIN_BURST, MIXED_BURST} burst_kind_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_opcode = spq_pkg::OP_QUERY;
  logic [spq_pkg::KEY_W-1:0] in_item_key = '0;
  logic [spq_pkg::TAG_W-1:0] in_item_tag = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_descending_order = 1'b0;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic [3:0]                out_insert_index;
  logic [spq_pkg::KEY_W-1:0] out_removed_key;
  logic [spq_pkg::TAG_W-1:0] out_removed_tag;
  logic                      out_head_valid;
  logic [spq_pkg::KEY_W-1:0] out_head_key;
  logic [spq_pkg::TAG_W-1:0] out_head_tag;
  logic [4:0]                out_count;

  logic [spq_pkg::KEY_W-1:0] queue_keys [QUEUE_DEPTH];
  logic [spq_pkg::TAG_W-1:0] queue_tags [QUEUE_DEPTH];
  int                        queue_len = 0;
  bit                        serve_descending = 1'b0;

  queue_result_t    pending_results [$];
  int               mismatch_count = 0;
  int               stall_cycles = 0;
  bit               gap_free = 1'b0;

  sorted_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_item_key          (in_item_key),
    .in_item_tag          (in_item_tag),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_descending_order (cfg_descending_order),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_insert_index     (out_insert_index),
    .out_removed_key      (out_removed_key),
    .out_removed_tag      (out_removed_tag),
    .out_head_valid       (out_head_valid),
    .out_head_key         (out_head_key),
    .out_head_tag         (out_head_tag),
    .out_count            (out_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit key_served_first(logic [spq_pkg::KEY_W-1:0] a,
                                          logic [spq_pkg::KEY_W-1:0] b);
    return serve_descending ? (a > b) : (a < b);
  endfunction

  function automatic queue_result_t apply_request(logic [1:0] op,
                                                  logic [spq_pkg::KEY_W-1:0] key,
                                                  logic [spq_pkg::TAG_W-1:0] tag);
    queue_result_t res;
    int            pos;
    res = '0;
    if (op == spq_pkg::OP_OFFER) begin
      if (queue_len >= QUEUE_DEPTH) begin
        res.status = spq_pkg::STS_FULL;
      end else begin
        pos = 0;
        while (pos < queue_len && !key_served_first(key, queue_keys[pos])) pos++;
        for (int i = queue_len; i > pos; i--) begin
          queue_keys[i] = queue_keys[i-1];
          queue_tags[i] = queue_tags[i-1];
        end
        queue_keys[pos] = key;
        queue_tags[pos] = tag;
        queue_len++;
        res.insert_index = pos[3:0];
      end
    end else if (op == spq_pkg::OP_POLL) begin
      if (queue_len == 0) begin
        res.status = spq_pkg::STS_EMPTY;
      end else begin
        res.removed_key = queue_keys[0];
        res.removed_tag = queue_tags[0];
        for (int i = 1; i < queue_len; i++) begin
          queue_keys[i-1] = queue_keys[i];
          queue_tags[i-1] = queue_tags[i];
        end
        queue_len--;
      end
    end
    res.head_valid = (queue_len != 0);
    res.head_key   = (queue_len != 0) ? queue_keys[0] : '0;
    res.head_tag   = (queue_len != 0) ? queue_tags[0] : '0;
    res.count      = queue_len[4:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    queue_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status %0d count %0d", out_status, out_count);
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", 16'(exp_res.status), 16'(out_status));
        check_field("insert_index", 16'(exp_res.insert_index), 16'(out_insert_index));
        check_field("removed_key", exp_res.removed_key, out_removed_key);
        check_field("removed_tag", exp_res.removed_tag, out_removed_tag);
        check_field("head_valid", 16'(exp_res.head_valid), 16'(out_head_valid));
        check_field("head_key", exp_res.head_key, out_head_key);
        check_field("head_tag", exp_res.head_tag, out_head_tag);
        check_field("count", 16'(exp_res.count), 16'(out_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic sender_gap();
    int roll;
    int cycles;
    roll = $urandom_range(0, 99);
    if (gap_free || roll < 55) cycles = 0;
    else if (roll < 90) cycles = $urandom_range(1, 3);
    else cycles = $urandom_range(8, 40);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic send_request(input logic [1:0] op, input logic [spq_pkg::KEY_W-1:0] key,
                              input logic [spq_pkg::TAG_W-1:0] tag);
    start       <= 1'b1;
    in_opcode   <= op;
    in_item_key <= key;
    in_item_tag <= tag;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(op, key, tag));
    sender_gap();
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sort_order(input bit descending);
    wait_until_drained();
    cfg_valid            <= 1'b1;
    cfg_descending_order <= descending;
    do @(posedge clk); while (!cfg_ready);
    serve_descending = descending;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_queue();
    send_request(spq_pkg::OP_POLL, 16'hFFFF, 16'hFFFF);
    send_request(spq_pkg::OP_QUERY, 16'h0000, 16'h0000);
    send_request(OP_RESERVED, 16'hA5A5, 16'h5A5A);
  endtask

  task automatic test_ascending_order();
    write_sort_order(1'b0);
    send_request(spq_pkg::OP_OFFER, 16'hFFFF, 16'h0000);
    send_request(spq_pkg::OP_OFFER, 16'h0000, 16'hFFFF);
    send_request(spq_pkg::OP_OFFER, 16'h8000, 16'h0001);
    send_request(spq_pkg::OP_OFFER, 16'h8000, 16'h0002);
    send_request(spq_pkg::OP_OFFER, 16'h8000, 16'h0003);
    send_request(spq_pkg::OP_POLL, 16'h1234, 16'h4321);
    send_request(spq_pkg::OP_POLL, 16'h0000, 16'h0000);
  endtask

  task automatic test_descending_order();
    write_sort_order(1'b1);
    send_request(spq_pkg::OP_OFFER, 16'h0001, 16'h0010);
    send_request(spq_pkg::OP_OFFER, 16'hFFFF, 16'h0011);
    send_request(spq_pkg::OP_OFFER, 16'hFFFF, 16'h0012);
    send_request(spq_pkg::OP_POLL, 16'h0000, 16'h0000);
  endtask

  task automatic test_full_queue();
    while (queue_len < QUEUE_DEPTH)
      send_request(spq_pkg::OP_OFFER, 16'($urandom), 16'($urandom));
    send_request(spq_pkg::OP_OFFER, 16'h0000, 16'hFFFF);
    send_request(spq_pkg::OP_QUERY, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_random_traffic();
    burst_kind_t               burst;
    int                        roll;
    logic [1:0]                op;
    logic [spq_pkg::KEY_W-1:0] key;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_sort_order(phase[0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          burst    = burst_kind_t'($urandom_range(0, 2));
          gap_free = ($urandom_range(0, 3) == 0);
        end
        roll = $urandom_range(0, 99);
        case (burst)
          FILL_BURST: begin
            op = (roll < 70) ? spq_pkg::OP_OFFER :
                 (roll < 90) ? spq_pkg::OP_POLL : spq_pkg::OP_QUERY;
          end
          DRAIN_BURST: begin
            op = (roll < 25) ? spq_pkg::OP_OFFER :
                 (roll < 88) ? spq_pkg::OP_POLL : spq_pkg::OP_QUERY;
          end
          default: begin
            op = (roll < 45) ? spq_pkg::OP_OFFER :
                 (roll < 90) ? spq_pkg::OP_POLL : spq_pkg::OP_QUERY;
          end
        endcase
        if (op == spq_pkg::OP_QUERY && $urandom_range(0, 1) == 1) op = OP_RESERVED;
        roll = $urandom_range(0, 9);
        if (roll < 4) key = 16'($urandom_range(0, 7));
        else if (roll == 4) key = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        else key = 16'($urandom);
        send_request(op, key, 16'($urandom));
      end
    end
    gap_free = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_ascending_order();
    test_descending_order();
    test_full_queue();
    test_random_traffic();
    wait_until_drained();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
